>>> sv/pf32_pkg.sv
// Package for the trial-division prime factorizer: status codes, microcode
// field types, step addresses and the control-store contents.
// No dependencies.
package pf32_pkg;

  typedef logic [1:0] status_t;
  typedef logic [3:0] pc_t;
  typedef logic [3:0] cond_t;
  typedef logic [3:0] act_t;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_ONE  = 2'd1;
  localparam status_t STATUS_ZERO = 2'd2;

  // Branch conditions.
  localparam cond_t COND_ALWAYS    = 4'd0;
  localparam cond_t COND_NOT_START = 4'd1;
  localparam cond_t COND_P_ZERO    = 4'd2;
  localparam cond_t COND_P_ONE     = 4'd3;
  localparam cond_t COND_P_ODD     = 4'd4;
  localparam cond_t COND_SQ_GT_P   = 4'd5;
  localparam cond_t COND_DIV_WAIT  = 4'd6;
  localparam cond_t COND_REM_NZ    = 4'd7;
  localparam cond_t COND_P_GT1     = 4'd8;

  // Datapath actions.
  localparam act_t ACT_NONE      = 4'd0;
  localparam act_t ACT_LOAD      = 4'd1;
  localparam act_t ACT_EMIT_ZERO = 4'd2;
  localparam act_t ACT_EMIT_ONE  = 4'd3;
  localparam act_t ACT_TAKE2     = 4'd4;
  localparam act_t ACT_INIT3     = 4'd5;
  localparam act_t ACT_DIV_START = 4'd6;
  localparam act_t ACT_TAKE_D    = 4'd7;
  localparam act_t ACT_NEXT_D    = 4'd8;
  localparam act_t ACT_TAKE_P    = 4'd9;
  localparam act_t ACT_FLUSH     = 4'd10;

  // Step addresses.
  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_ZERO      = 4'd1;
  localparam pc_t PC_ONE       = 4'd2;
  localparam pc_t PC_EVEN      = 4'd3;
  localparam pc_t PC_EVEN_LOOP = 4'd4;
  localparam pc_t PC_ODD_TEST  = 4'd5;
  localparam pc_t PC_DIV_WAIT  = 4'd6;
  localparam pc_t PC_REM_TEST  = 4'd7;
  localparam pc_t PC_REDIVIDE  = 4'd8;
  localparam pc_t PC_TAIL      = 4'd9;
  localparam pc_t PC_DONE      = 4'd10;

  // When the condition holds the sequencer jumps to tgt and performs act_t;
  // otherwise it performs act_f and falls through to the next step.
  typedef struct packed {
    cond_t cond;
    pc_t   tgt;
    act_t  act_t_op;
    act_t  act_f_op;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    unique case (pc)
      PC_IDLE:      cw = '{COND_NOT_START, PC_IDLE,      ACT_NONE,      ACT_LOAD};
      PC_ZERO:      cw = '{COND_P_ZERO,    PC_IDLE,      ACT_EMIT_ZERO, ACT_NONE};
      PC_ONE:       cw = '{COND_P_ONE,     PC_IDLE,      ACT_EMIT_ONE,  ACT_NONE};
      PC_EVEN:      cw = '{COND_P_ODD,     PC_ODD_TEST,  ACT_INIT3,     ACT_TAKE2};
      PC_EVEN_LOOP: cw = '{COND_ALWAYS,    PC_EVEN,      ACT_NONE,      ACT_NONE};
      PC_ODD_TEST:  cw = '{COND_SQ_GT_P,   PC_TAIL,      ACT_NONE,      ACT_DIV_START};
      PC_DIV_WAIT:  cw = '{COND_DIV_WAIT,  PC_DIV_WAIT,  ACT_NONE,      ACT_NONE};
      PC_REM_TEST:  cw = '{COND_REM_NZ,    PC_ODD_TEST,  ACT_NEXT_D,    ACT_TAKE_D};
      PC_REDIVIDE:  cw = '{COND_ALWAYS,    PC_DIV_WAIT,  ACT_DIV_START, ACT_NONE};
      PC_TAIL:      cw = '{COND_P_GT1,     PC_DONE,      ACT_TAKE_P,    ACT_NONE};
      PC_DONE:      cw = '{COND_ALWAYS,    PC_IDLE,      ACT_FLUSH,     ACT_NONE};
      default:      cw = '{COND_ALWAYS,    PC_IDLE,      ACT_NONE,      ACT_NONE};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/pf32_div.sv
// Restoring divider, one quotient bit per cycle, for the prime factorizer.
// Standalone; no package dependencies.
module pf32_div #(
  parameter int WIDTH = 32,
  parameter int DW    = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic             rem_nz
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    div_r, div_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[WIDTH-1]};
    rem_sub  = rem_sh - {1'b0, div_r};
    ge       = rem_sh >= {1'b0, div_r};
    run_nxt  = run_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CW'(WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (run_r) begin
      // The remainder stays below the divisor, so it fits in DW bits.
      rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = |rem_r;

endmodule

>>> sv/prime_factorizer_32_core.sv
// Top level of the trial-division prime factorizer: a microcoded sequencer
// over a small datapath. Depends on pf32_pkg and pf32_div.
//
//   channel   ports                                   transfer
//   input     start, busy, in_number                  start high while busy low
//   result    out_valid, out_factor, out_status,      out_valid high, one cycle
//             out_last
//
// An input 0 puts its one result on the ports from step PC_ZERO, an input 1 from
// step PC_ONE, each through the registered outputs.
// Otherwise each factor 2 takes steps PC_EVEN and PC_EVEN_LOOP, and each odd
// divisor tried waits on the bit-serial divider, which works through WIDTH
// quotient bits. Results leave at most one per cycle and the receiver cannot
// stall them. Reset returns the sequencer to idle.
module prime_factorizer_32_core #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       in_number,
  output logic              busy,
  output logic              out_valid,
  output logic [31:0]       out_factor,
  output pf32_pkg::status_t out_status,
  output logic              out_last
);
  import pf32_pkg::*;

  localparam int DW = (WIDTH + 1) / 2 + 2;
  localparam int SW = WIDTH + 2;

  pc_t              pc_r, pc_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [SW-1:0]    sq_r, sq_nxt;
  logic [WIDTH-1:0] pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_factor_r, out_factor_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  ctrl_word_t       cw;
  logic             cond_true;
  act_t             act;
  logic             push_en;
  logic [WIDTH-1:0] push_val;
  logic             div_start;
  logic             div_done;
  logic             div_rem_nz;
  logic [WIDTH-1:0] div_quo;

  pf32_div #(
    .WIDTH (WIDTH),
    .DW    (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (p_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  always_comb begin
    cw = ucode(pc_r);
    unique case (cw.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NOT_START: cond_true = !start;
      COND_P_ZERO:    cond_true = (p_r == '0);
      COND_P_ONE:     cond_true = (p_r == WIDTH'(1));
      COND_P_ODD:     cond_true = p_r[0];
      COND_SQ_GT_P:   cond_true = (sq_r > SW'(p_r));
      COND_DIV_WAIT:  cond_true = !div_done;
      COND_REM_NZ:    cond_true = div_rem_nz;
      COND_P_GT1:     cond_true = (p_r > WIDTH'(1));
      default:        cond_true = 1'b1;
    endcase
    act    = cond_true ? cw.act_t_op : cw.act_f_op;
    pc_nxt = cond_true ? cw.tgt : pc_r + pc_t'(1);

    p_nxt          = p_r;
    d_nxt          = d_r;
    sq_nxt         = sq_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = 1'b0;
    out_factor_nxt = out_factor_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    push_en        = 1'b0;
    push_val       = '0;
    div_start      = 1'b0;

    unique case (act)
      ACT_NONE: ;
      ACT_LOAD: begin
        p_nxt      = WIDTH'(in_number);
        pend_v_nxt = 1'b0;
      end
      ACT_EMIT_ZERO: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = '0;
        out_status_nxt = STATUS_ZERO;
        out_last_nxt   = 1'b1;
      end
      ACT_EMIT_ONE: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = '0;
        out_status_nxt = STATUS_ONE;
        out_last_nxt   = 1'b1;
      end
      ACT_TAKE2: begin
        push_en  = 1'b1;
        push_val = WIDTH'(2);
        p_nxt    = p_r >> 1;
      end
      ACT_INIT3: begin
        d_nxt  = DW'(3);
        sq_nxt = SW'(9);
      end
      ACT_DIV_START: div_start = 1'b1;
      ACT_TAKE_D: begin
        push_en  = 1'b1;
        push_val = WIDTH'(d_r);
        p_nxt    = div_quo;
      end
      ACT_NEXT_D: begin
        // (d + 2)^2 = d^2 + 4d + 4
        d_nxt  = d_r + DW'(2);
        sq_nxt = sq_r + SW'({d_r, 2'b00}) + SW'(4);
      end
      ACT_TAKE_P: begin
        push_en  = 1'b1;
        push_val = p_r;
      end
      ACT_FLUSH: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = 32'(pend_r);
        out_status_nxt = STATUS_OK;
        out_last_nxt   = 1'b1;
        pend_v_nxt     = 1'b0;
      end
      default: ;
    endcase

    // Each factor is held back until the next one is found, so that the final one
    // can carry the last mark; finding a new factor releases the held one.
    if (push_en) begin
      if (pend_v_r) begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = 32'(pend_r);
        out_status_nxt = STATUS_OK;
        out_last_nxt   = 1'b0;
      end
      pend_nxt   = push_val;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    sq_r         <= sq_nxt;
    pend_r       <= pend_nxt;
    out_factor_r <= out_factor_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = (pc_r != PC_IDLE);
  assign out_valid  = out_valid_r;
  assign out_factor = out_factor_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> tb/sv/prime_factorizer_32_core_tb.sv
// Self-checking testbench for prime_factorizer_32_core: drives numbers through the
// start/busy command port and checks every factor transfer against a trial-division
// predictor. Depends on pf32_pkg and the core RTL.
`timescale 1ns / 100ps

module prime_factorizer_32_core_tb;
  import pf32_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int STALL_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] factor;
    status_t     status;
    logic        last;
  } factor_result_t;

  class factor_scoreboard;
    factor_result_t pending_factors[$];
    int unsigned    mismatches;
    int unsigned    numbers_sent;
    int unsigned    factors_checked;

    task report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Trial division: strip the twos, then every odd divisor while its square
    // does not exceed the quotient; a quotient above one left over is prime.
    function void queue_prime_factors(input logic [31:0] number);
      logic [63:0]    quotient;
      logic [63:0]    divisor;
      logic [31:0]    found[$];
      factor_result_t entry;
      numbers_sent++;
      quotient = 64'(number);
      if (quotient == 0) begin
        pending_factors.push_back('{32'd0, STATUS_ZERO, 1'b1});
        return;
      end
      if (quotient == 1) begin
        pending_factors.push_back('{32'd0, STATUS_ONE, 1'b1});
        return;
      end
      while (quotient[0] == 1'b0) begin
        found.push_back(32'd2);
        quotient = quotient >> 1;
      end
      divisor = 64'd3;
      while (divisor <= quotient / divisor) begin
        while (quotient % divisor == 0) begin
          found.push_back(divisor[31:0]);
          quotient = quotient / divisor;
        end
        divisor = divisor + 2;
      end
      if (quotient > 1) found.push_back(quotient[31:0]);
      foreach (found[i]) begin
        entry.factor = found[i];
        entry.status = STATUS_OK;
        entry.last   = (i == found.size() - 1);
        pending_factors.push_back(entry);
      end
    endfunction

    task check_factor(input logic [31:0] factor, input status_t status, input logic last);
      factor_result_t want;
      factors_checked++;
      if (pending_factors.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer factor=%0d status=%0d last=%b",
                                  factor, status, last));
        return;
      end
      want = pending_factors.pop_front();
      if (factor !== want.factor || status !== want.status || last !== want.last)
        report_mismatch($sformatf("got factor=%0d status=%0d last=%b, want %0d/%0d/%b",
                                  factor, status, last, want.factor, want.status,
                                  want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_number = 32'd0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_factor;
  status_t     out_status;
  logic        out_last;

  bit               gaps_on = 1'b1;
  int unsigned      stall_cycles;
  factor_scoreboard sb = new();

  logic [31:0] directed_numbers [17] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9,
    32'd11025,          // 3^2 * 5^2 * 7^2: odd composites never divide
    32'd63001,          // square of the prime 251
    32'd65521,          // prime
    32'd1000003,        // prime with a longer divisor search
    32'd223092870,      // primes 2 through 23
    32'h8000_0000,      // thirty-one factors of two
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd3486784401,     // 3^20
    32'hFFFE_0001       // 65535^2
  };

  prime_factorizer_32_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_number (in_number),
    .busy      (busy),
    .out_valid (out_valid),
    .out_factor(out_factor),
    .out_status(out_status),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  // Mostly smooth numbers built from factors up to 255, so each one is cheap
  // to factor while still reaching the high bits; the rest are noise.
  function automatic logic [31:0] random_number();
    logic [63:0] value;
    int unsigned pick;
    int unsigned mult;
    int unsigned shift;
    pick = $urandom_range(99);
    if (pick < 4) return 32'($urandom_range(1));
    if (pick < 20) return 32'($urandom_range(16'hFFFF));
    value = 64'd1;
    repeat ($urandom_range(8, 1)) begin
      mult = $urandom_range(255, 2);
      if (value * mult <= 64'hFFFF_FFFF) value = value * mult;
    end
    if ($urandom_range(1) == 1) begin
      shift = $urandom_range(31);
      while (shift > 0 && (value << shift) > 64'hFFFF_FFFF) shift--;
      value = value << shift;
    end
    return value[31:0];
  endfunction

  // Start stays high from one transfer into the next unless a gap is taken.
  task automatic send_number(input logic [31:0] number);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 14);
    end
    start     <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (busy);
    sb.queue_prime_factors(number);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_factor(out_factor, out_status, out_last);
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((start && !busy) || out_valid)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("No transfer for %0d cycles, giving up", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 40 && i < 70);
      send_number(random_number());
    end
    start <= 1'b0;
    while (sb.pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Factorized %0d numbers and checked %0d factor transfers, %0d mismatches.",
             sb.numbers_sent, sb.factors_checked, sb.mismatches);
    $display("Inputs covered zero, one, primes, prime powers and random smooth products.");
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
